// ===== src/sdi_pkg.sv =====
// ----------------------------------------------------------------------------
// SD card SPI init sequencer package
// Shared types, command codes and result helpers for the init sequencer.
// ----------------------------------------------------------------------------
package sdi_pkg;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_CMD0  = 4'd1,
        PH_CMD8  = 4'd2,
        PH_V2_55 = 4'd3,
        PH_V2_41 = 4'd4,
        PH_CMD58 = 4'd5,
        PH_PR_55 = 4'd6,
        PH_PR_41 = 4'd7,
        PH_V1_55 = 4'd8,
        PH_V1_41 = 4'd9,
        PH_MMC_1 = 4'd10,
        PH_CMD16 = 4'd11
    } t_phase;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_MMC  = 3'd1,
        KIND_V1   = 3'd2,
        KIND_V2   = 3'd3,
        KIND_V2HC = 3'd4,
        KIND_ERR  = 3'd5
    } t_kind;

    localparam logic [1:0] RES_OK     = 2'd0;
    localparam logic [1:0] RES_R1_ERR = 2'd1;
    localparam logic [1:0] RES_FAIL   = 2'd2;

    localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
    localparam logic [5:0] CMD_SEND_OP_COND = 6'd1;
    localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
    localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
    localparam logic [5:0] ACMD_OP_COND     = 6'd41;
    localparam logic [5:0] CMD_APP          = 6'd55;
    localparam logic [5:0] CMD_READ_OCR     = 6'd58;

    localparam logic [7:0]  CRC_CMD0     = 8'h95;
    localparam logic [7:0]  CRC_CMD8     = 8'h87;
    localparam logic [7:0]  CRC_DUMMY    = 8'h01;
    localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
    localparam logic [15:0] ECHO_IF_COND = 16'h01AA;
    localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
    localparam logic [31:0] ARG_BLK_512  = 32'd512;
    localparam logic [7:0]  R1_IDLE      = 8'h01;

    localparam logic OP_START = 1'b0;

    // Config register indexes.
    localparam logic CFG_IDLE_LIMIT  = 1'b0;
    localparam logic CFG_READY_LIMIT = 1'b1;

    localparam logic [7:0]  IDLE_LIMIT_RST  = 8'd20;
    localparam logic [15:0] READY_LIMIT_RST = 16'd65534;

    typedef struct packed {
        logic        issue;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_argument;
        logic [7:0]  cmd_crc;
        logic        want_trailer;
        logic        done_res;
        t_kind       card_kind;
        logic [1:0]  result_code;
        logic [7:0]  final_r1;
    } t_result;

    function automatic t_result mk_cmd(input logic [5:0] idx, input logic [31:0] arg,
                                       input logic [7:0] crc, input logic trl);
        t_result r;
        r              = '0;
        r.issue        = 1'b1;
        r.cmd_index    = idx;
        r.cmd_argument = arg;
        r.cmd_crc      = crc;
        r.want_trailer = trl;
        return r;
    endfunction

    function automatic t_result mk_done(input t_kind kind, input logic [7:0] last);
        t_result r;
        r           = '0;
        r.done_res  = 1'b1;
        r.card_kind = kind;
        r.final_r1  = last;
        if (kind == KIND_MMC || kind == KIND_V1 || kind == KIND_V2 || kind == KIND_V2HC) begin
            r.result_code = RES_OK;
        end else if (last != 8'd0) begin
            r.result_code = RES_R1_ERR;
        end else begin
            r.result_code = RES_FAIL;
        end
        return r;
    endfunction

endpackage

// ===== src/sd_card_spi_init_sequencer.sv =====
// ----------------------------------------------------------------------------
// SD card SPI init sequencer
// Command-level sequencer for SPI-mode SD/MMC card initialization.
// ----------------------------------------------------------------------------
// Usage: send a start item (tuser = 0) to begin; the block answers with the
// first command to send. After each command has been sent on the SPI side,
// send its response as an item (tuser = 1, tdata = R1 and trailer bytes).
// Each such item yields one result: either the next command (tuser bit 0)
// or the final card classification (tuser bit 1). A response that arrives
// while no sequence is running yields no result. A start while busy restarts.
// Retry limits are to be written on the config port while the block is idle;
// the block does not enforce this. An accepted item passes from the input
// register through the decision logic into the output register.
// Throughput is one item per cycle; the input register advances whenever
// the output register is empty or being taken in the same cycle.
// When the receiver stalls, the result holds and at most one further item
// is held in the input register before tready drops.
// Reset returns the sequence to idle and loads the default retry limits.
// ----------------------------------------------------------------------------
module sd_card_spi_init_sequencer
    import sdi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [7:0] resp_r1, [39:8] resp_trailer
    input  logic        i_s_axis_tuser,   // [0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [5:0] cmd_index, [37:6] cmd_argument, [45:38] cmd_crc, [46] want_trailer,
    // [49:47] card_kind, [51:50] result_code, [59:52] final_r1, [63:60] zero
    output logic [63:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser    // [0] issue, [1] done_res
);

    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_r1;
    logic [31:0] r_in_tr;
    logic        r_out_valid;
    t_result     r_out;
    logic        step;
    logic        res_valid;
    t_result     res;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op <= i_s_axis_tuser;
            r_in_r1 <= i_s_axis_tdata[7:0];
            r_in_tr <= i_s_axis_tdata[39:8];
        end
    end

    sdi_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_op        (r_in_op),
        .i_r1        (r_in_r1),
        .i_trailer   (r_in_tr),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = {r_out.done_res, r_out.issue};
    assign o_m_axis_tdata  = {4'd0, r_out.final_r1, r_out.result_code, r_out.card_kind,
                              r_out.want_trailer, r_out.cmd_crc, r_out.cmd_argument,
                              r_out.cmd_index};

endmodule

// ===== src/sdi_core.sv =====
// ----------------------------------------------------------------------------
// SD card SPI init sequencer core
// Holds the sequence state and limit registers and decides, for one item,
// the next command to send or the final card classification.
// ----------------------------------------------------------------------------
module sdi_core
    import sdi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_step,
    input  logic        i_op,
    input  logic [7:0]  i_r1,
    input  logic [31:0] i_trailer,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_retries, n_retries;
    logic [7:0]  r_last_r1, n_last_r1;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_idle_lim;
    logic [15:0] r_ready_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_lim  <= IDLE_LIMIT_RST;
            r_ready_lim <= READY_LIMIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDLE_LIMIT) begin
                r_idle_lim <= i_cfg_wdata[7:0];
            end else begin
                r_ready_lim <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_retries <= '0;
            r_last_r1 <= '0;
            r_kind    <= KIND_NONE;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_retries <= n_retries;
            r_last_r1 <= n_last_r1;
            r_kind    <= n_kind;
        end
    end

    always_comb begin
        logic v_fin;
        v_fin       = 1'b0;
        n_phase     = r_phase;
        n_retries   = r_retries;
        n_last_r1   = r_last_r1;
        n_kind      = r_kind;
        o_res_valid = 1'b1;
        o_res       = '0;
        if (i_op == OP_START) begin
            n_kind    = KIND_NONE;
            n_last_r1 = '0;
            n_retries = {8'd0, r_idle_lim};
            o_res     = mk_cmd(CMD_GO_IDLE, '0, CRC_CMD0, 1'b0);
            n_phase   = PH_CMD0;
        end else begin
            unique case (r_phase)
                PH_CMD0: begin
                    n_last_r1 = i_r1;
                    if (i_r1 == R1_IDLE) begin
                        o_res   = mk_cmd(CMD_SEND_IF_COND, ARG_IF_COND, CRC_CMD8, 1'b1);
                        n_phase = PH_CMD8;
                    end else if (r_retries != 16'd0) begin
                        n_retries = r_retries - 16'd1;
                        o_res     = mk_cmd(CMD_GO_IDLE, '0, CRC_CMD0, 1'b0);
                    end else begin
                        v_fin = 1'b1;
                    end
                end
                PH_CMD8: begin
                    if (i_r1 == R1_IDLE) begin
                        if (i_trailer[15:0] == ECHO_IF_COND) begin
                            n_retries = r_ready_lim;
                            o_res     = mk_cmd(CMD_APP, '0, CRC_DUMMY, 1'b0);
                            n_phase   = PH_V2_55;
                        end else begin
                            v_fin = 1'b1;
                        end
                    end else begin
                        o_res   = mk_cmd(CMD_APP, '0, CRC_DUMMY, 1'b0);
                        n_phase = PH_PR_55;
                    end
                end
                PH_V2_55: begin
                    o_res   = mk_cmd(ACMD_OP_COND, ARG_HCS, CRC_DUMMY, 1'b0);
                    n_phase = PH_V2_41;
                end
                PH_V2_41: begin
                    n_last_r1 = i_r1;
                    if (i_r1 == 8'd0) begin
                        o_res   = mk_cmd(CMD_READ_OCR, '0, CRC_DUMMY, 1'b1);
                        n_phase = PH_CMD58;
                    end else if (r_retries != 16'd0) begin
                        n_retries = r_retries - 16'd1;
                        o_res     = mk_cmd(CMD_APP, '0, CRC_DUMMY, 1'b0);
                        n_phase   = PH_V2_55;
                    end else begin
                        v_fin = 1'b1;
                    end
                end
                PH_CMD58: begin
                    if (i_r1 == 8'd0) begin
                        // OCR bit 30 is the card capacity status.
                        n_kind = i_trailer[30] ? KIND_V2HC : KIND_V2;
                    end
                    v_fin = 1'b1;
                end
                PH_PR_55: begin
                    o_res   = mk_cmd(ACMD_OP_COND, '0, CRC_DUMMY, 1'b0);
                    n_phase = PH_PR_41;
                end
                PH_PR_41: begin
                    n_last_r1 = i_r1;
                    n_retries = r_ready_lim;
                    if (i_r1 <= 8'd1) begin
                        n_kind  = KIND_V1;
                        o_res   = mk_cmd(CMD_APP, '0, CRC_DUMMY, 1'b0);
                        n_phase = PH_V1_55;
                    end else begin
                        n_kind  = KIND_MMC;
                        o_res   = mk_cmd(CMD_SEND_OP_COND, '0, CRC_DUMMY, 1'b0);
                        n_phase = PH_MMC_1;
                    end
                end
                PH_V1_55: begin
                    o_res   = mk_cmd(ACMD_OP_COND, '0, CRC_DUMMY, 1'b0);
                    n_phase = PH_V1_41;
                end
                PH_V1_41, PH_MMC_1: begin
                    n_last_r1 = i_r1;
                    if (i_r1 == 8'd0) begin
                        o_res   = mk_cmd(CMD_SET_BLOCKLEN, ARG_BLK_512, CRC_DUMMY, 1'b0);
                        n_phase = PH_CMD16;
                    end else if (r_retries != 16'd0) begin
                        n_retries = r_retries - 16'd1;
                        if (r_phase == PH_V1_41) begin
                            o_res   = mk_cmd(CMD_APP, '0, CRC_DUMMY, 1'b0);
                            n_phase = PH_V1_55;
                        end else begin
                            o_res = mk_cmd(CMD_SEND_OP_COND, '0, CRC_DUMMY, 1'b0);
                        end
                    end else begin
                        n_kind = KIND_ERR;
                        v_fin  = 1'b1;
                    end
                end
                PH_CMD16: begin
                    if (i_r1 != 8'd0) begin
                        n_kind = KIND_ERR;
                    end
                    v_fin = 1'b1;
                end
                default: begin
                    // A response while idle is dropped.
                    n_phase     = PH_IDLE;
                    o_res_valid = 1'b0;
                end
            endcase
        end
        if (v_fin) begin
            o_res   = mk_done(n_kind, n_last_r1);
            n_phase = PH_IDLE;
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the SD card SPI init sequencer
// Plays the part of a card that answers each command the block asks for,
// predicts every command and classification the block should emit, and
// compares them field by field while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import sdi_pkg::*;

    localparam logic OP_RESPONSE       = 1'b1;
    localparam int   CYCLE_LIMIT       = 1_000_000;
    localparam int   ITEMS_PER_SETTING = 206;
    localparam int   DRAIN_CYCLES      = 6;
    localparam int   PRESSURE_AT       = 3000;
    localparam int   PRESSURE_LEN      = 400;

    localparam logic [7:0]  IDLE_SETTINGS  [7] = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd0, 8'd255, 8'd2};
    localparam logic [15:0] READY_SETTINGS [7] = '{16'd0, 16'd2, 16'd65535, 16'd1,
                                                   16'd65535, 16'd0, 16'd3};

    class cmd_scoreboard;
        t_phase      phase;
        logic [15:0] retries_left;
        logic [7:0]  last_r1;
        t_kind       kind;
        logic [7:0]  idle_limit;
        logic [15:0] ready_limit;
        t_result     replies_due[$];
        int          errors;

        function new();
            phase        = PH_IDLE;
            retries_left = '0;
            last_r1      = '0;
            kind         = KIND_NONE;
            idle_limit   = IDLE_LIMIT_RST;
            ready_limit  = READY_LIMIT_RST;
            errors       = 0;
        endfunction

        function void set_limits(logic [7:0] idle_val, logic [15:0] ready_val);
            idle_limit  = idle_val;
            ready_limit = ready_val;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function t_result issue_cmd(logic [5:0] idx, logic [31:0] arg, logic [7:0] crc,
                                    logic trl, t_phase nxt);
            t_result r;
            r              = '0;
            r.issue        = 1'b1;
            r.cmd_index    = idx;
            r.cmd_argument = arg;
            r.cmd_crc      = crc;
            r.want_trailer = trl;
            phase          = nxt;
            return r;
        endfunction

        function t_result finish_seq();
            t_result r;
            r           = '0;
            r.done_res  = 1'b1;
            r.card_kind = kind;
            r.final_r1  = last_r1;
            if (kind == KIND_MMC || kind == KIND_V1 || kind == KIND_V2 || kind == KIND_V2HC) begin
                r.result_code = RES_OK;
            end else if (last_r1 != 8'd0) begin
                r.result_code = RES_R1_ERR;
            end else begin
                r.result_code = RES_FAIL;
            end
            phase = PH_IDLE;
            return r;
        endfunction

        // Advances the predicted sequencer by one accepted item. Returns 1 when
        // the item produces a result, 0 when the block drops it.
        function bit note_item(logic op, logic [7:0] r1, logic [31:0] tr);
            t_result r;
            r = '0;
            if (op == OP_START) begin
                kind         = KIND_NONE;
                last_r1      = '0;
                retries_left = {8'd0, idle_limit};
                r = issue_cmd(CMD_GO_IDLE, 32'd0, CRC_CMD0, 1'b0, PH_CMD0);
            end else begin
                case (phase)
                    PH_CMD0: begin
                        last_r1 = r1;
                        if (r1 == R1_IDLE) begin
                            r = issue_cmd(CMD_SEND_IF_COND, ARG_IF_COND, CRC_CMD8, 1'b1, PH_CMD8);
                        end else if (retries_left != 0) begin
                            retries_left--;
                            r = issue_cmd(CMD_GO_IDLE, 32'd0, CRC_CMD0, 1'b0, PH_CMD0);
                        end else begin
                            r = finish_seq();
                        end
                    end
                    PH_CMD8: begin
                        if (r1 == R1_IDLE) begin
                            if (tr[15:0] == ECHO_IF_COND) begin
                                retries_left = ready_limit;
                                r = issue_cmd(CMD_APP, 32'd0, CRC_DUMMY, 1'b0, PH_V2_55);
                            end else begin
                                r = finish_seq();
                            end
                        end else begin
                            // Older card: probe with a plain ACMD41 first.
                            r = issue_cmd(CMD_APP, 32'd0, CRC_DUMMY, 1'b0, PH_PR_55);
                        end
                    end
                    PH_V2_55: r = issue_cmd(ACMD_OP_COND, ARG_HCS, CRC_DUMMY, 1'b0, PH_V2_41);
                    PH_V2_41: begin
                        last_r1 = r1;
                        if (r1 == 8'd0) begin
                            r = issue_cmd(CMD_READ_OCR, 32'd0, CRC_DUMMY, 1'b1, PH_CMD58);
                        end else if (retries_left != 0) begin
                            retries_left--;
                            r = issue_cmd(CMD_APP, 32'd0, CRC_DUMMY, 1'b0, PH_V2_55);
                        end else begin
                            r = finish_seq();
                        end
                    end
                    PH_CMD58: begin
                        if (r1 == 8'd0) begin
                            if (tr[30]) begin
                                kind = KIND_V2HC;
                            end else begin
                                kind = KIND_V2;
                            end
                        end
                        r = finish_seq();
                    end
                    PH_PR_55: r = issue_cmd(ACMD_OP_COND, 32'd0, CRC_DUMMY, 1'b0, PH_PR_41);
                    PH_PR_41: begin
                        last_r1      = r1;
                        retries_left = ready_limit;
                        if (r1 <= 8'd1) begin
                            kind = KIND_V1;
                            r = issue_cmd(CMD_APP, 32'd0, CRC_DUMMY, 1'b0, PH_V1_55);
                        end else begin
                            kind = KIND_MMC;
                            r = issue_cmd(CMD_SEND_OP_COND, 32'd0, CRC_DUMMY, 1'b0, PH_MMC_1);
                        end
                    end
                    PH_V1_55: r = issue_cmd(ACMD_OP_COND, 32'd0, CRC_DUMMY, 1'b0, PH_V1_41);
                    PH_V1_41, PH_MMC_1: begin
                        last_r1 = r1;
                        if (r1 == 8'd0) begin
                            r = issue_cmd(CMD_SET_BLOCKLEN, ARG_BLK_512, CRC_DUMMY, 1'b0,
                                          PH_CMD16);
                        end else if (retries_left != 0) begin
                            retries_left--;
                            if (phase == PH_V1_41) begin
                                r = issue_cmd(CMD_APP, 32'd0, CRC_DUMMY, 1'b0, PH_V1_55);
                            end else begin
                                r = issue_cmd(CMD_SEND_OP_COND, 32'd0, CRC_DUMMY, 1'b0,
                                              PH_MMC_1);
                            end
                        end else begin
                            kind = KIND_ERR;
                            r = finish_seq();
                        end
                    end
                    PH_CMD16: begin
                        if (r1 != 8'd0) begin
                            kind = KIND_ERR;
                        end
                        r = finish_seq();
                    end
                    default: begin
                        phase = PH_IDLE;
                        return 1'b0;
                    end
                endcase
            end
            replies_due.push_back(r);
            return 1'b1;
        endfunction

        function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [63:0] d, logic [1:0] u);
            t_result e;
            if (replies_due.size() == 0) begin
                $error("result with no item pending: tuser 0x%0h tdata 0x%0h", u, d);
                errors++;
                return;
            end
            e = replies_due.pop_front();
            check_field("issue", 32'(e.issue), 32'(u[0]));
            check_field("done_res", 32'(e.done_res), 32'(u[1]));
            check_field("cmd_index", 32'(e.cmd_index), 32'(d[5:0]));
            check_field("cmd_argument", e.cmd_argument, d[37:6]);
            check_field("cmd_crc", 32'(e.cmd_crc), 32'(d[45:38]));
            check_field("want_trailer", 32'(e.want_trailer), 32'(d[46]));
            check_field("card_kind", 32'(e.card_kind), 32'(d[49:47]));
            check_field("result_code", 32'(e.result_code), 32'(d[51:50]));
            check_field("final_r1", 32'(e.final_r1), 32'(d[59:52]));
            check_field("tdata padding", 32'd0, 32'(d[63:60]));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [63:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    cmd_scoreboard board = new();
    bit            calm;

    sd_card_spi_init_sequencer u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            return 0;
        end else if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    task automatic send_item(input logic op, input logic [7:0] r1, input logic [31:0] tr,
                             output bit produced);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {tr, r1};
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        produced = board.note_item(op, r1, tr);
    endtask

    // Answers the command the block asked for last, mostly the way a real
    // card would, with some malformed and unexpected answers mixed in.
    task automatic random_item(output bit produced);
        logic        op;
        logic [7:0]  r1;
        logic [31:0] tr;
        int          roll;
        op   = OP_RESPONSE;
        r1   = 8'($urandom);
        tr   = $urandom;
        roll = $urandom_range(0, 99);
        if (board.phase == PH_IDLE) begin
            if (roll < 92) begin
                op = OP_START;
            end
        end else if (roll < 2) begin
            op = OP_START;
        end else begin
            roll = $urandom_range(0, 99);
            case (board.phase)
                PH_CMD0: begin
                    if (roll < 70) begin
                        r1 = R1_IDLE;
                    end else if (roll < 85) begin
                        r1 = 8'hFF;
                    end
                end
                PH_CMD8: begin
                    if (roll < 55) begin
                        r1 = R1_IDLE;
                        if ($urandom_range(0, 9) != 0) begin
                            tr[15:0] = ECHO_IF_COND;
                        end
                    end else if (roll < 85) begin
                        r1 = 8'h05;
                    end
                end
                PH_V2_41, PH_V1_41, PH_MMC_1: begin
                    if (roll < 30) begin
                        r1 = 8'h00;
                    end else if (roll < 80) begin
                        r1 = R1_IDLE;
                    end
                end
                PH_PR_41: begin
                    if (roll < 40) begin
                        r1 = 8'h00;
                    end else if (roll < 60) begin
                        r1 = R1_IDLE;
                    end else if (roll < 85) begin
                        r1 = 8'h05;
                    end
                end
                PH_CMD58, PH_CMD16: begin
                    if (roll < 85) begin
                        r1 = 8'h00;
                    end
                end
                default: ;
            endcase
        end
        send_item(op, r1, tr, produced);
    endtask

    task automatic write_limits(input logic [7:0] idle_val, input logic [15:0] ready_val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDLE_LIMIT;
        i_cfg_wdata <= {8'd0, idle_val};
        @(negedge i_clk);
        i_cfg_index <= CFG_READY_LIMIT;
        i_cfg_wdata <= ready_val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_limits(idle_val, ready_val);
    endtask

    // A dropped response may still sit in the block after the last result,
    // so the bench keeps waiting after it before the block counts as idle.
    task automatic drain_block();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold-off that fills the block.
    initial begin
        int  cycle_count;
        int  hold;
        int  stall;
        int  roll;
        logic rdy;
        cycle_count     = 0;
        hold            = 0;
        stall           = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle_count++;
            if (cycle_count == PRESSURE_AT) begin
                hold = PRESSURE_LEN;
            end
            roll = $urandom_range(0, 99);
            if (hold > 0) begin
                hold--;
                rdy = 1'b0;
            end else if (stall > 0) begin
                stall--;
                rdy = 1'b0;
            end else if (!calm && roll < 25) begin
                if ($urandom_range(0, 99) < 90) begin
                    stall = $urandom_range(0, 2);
                end else begin
                    stall = $urandom_range(10, 50);
                end
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_m_axis_tready <= rdy;
        end
    end

    initial begin
        calm = 1'b0;
        forever begin
            repeat ($urandom_range(100, 400)) @(posedge i_clk);
            calm = !calm;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        bit produced;
        int count;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_IDLE_LIMIT;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_START;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // High-capacity SD v2 card with one busy ACMD41 and one failed CMD0.
        send_item(OP_START,    8'hFF, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, 8'hFF, 32'hFFFF_FFFF, produced);
        send_item(OP_RESPONSE, R1_IDLE, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, R1_IDLE, 32'h0000_01AA, produced);
        send_item(OP_RESPONSE, 8'hFF, 32'hFFFF_FFFF, produced);
        send_item(OP_RESPONSE, R1_IDLE, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, 8'h00, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, 8'h00, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, 8'h00, 32'hC0FF_8000, produced);
        // A response with no sequence running is dropped.
        send_item(OP_RESPONSE, 8'h00, 32'h0000_0000, produced);
        // Rejected CMD8, probe answer says MMC, one busy CMD1.
        send_item(OP_START,    8'h00, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, R1_IDLE, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, 8'h05, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, 8'hFF, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, 8'h05, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, R1_IDLE, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, 8'h00, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, 8'h00, 32'h0000_0000, produced);
        // CMD8 echo mismatch ends with no card.
        send_item(OP_START,    8'h00, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, R1_IDLE, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, R1_IDLE, 32'hFFFF_01AB, produced);
        // Start while busy restarts from CMD0.
        send_item(OP_START,    8'h00, 32'h0000_0000, produced);
        send_item(OP_START,    8'hFF, 32'hFFFF_FFFF, produced);
        send_item(OP_RESPONSE, R1_IDLE, 32'h0000_0000, produced);
        send_item(OP_RESPONSE, R1_IDLE, 32'hFFFF_FFFF, produced);
        drain_block();

        for (int s = 0; s < 8; s++) begin
            if (s < 7) begin
                write_limits(IDLE_SETTINGS[s], READY_SETTINGS[s]);
            end else begin
                write_limits(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            end
            count = 0;
            while (count < ITEMS_PER_SETTING) begin
                random_item(produced);
                count += produced;
            end
            drain_block();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
